[src/utv_pkg.sv]
// Shared types and constants for the UTF-8 text validator.
package utv_pkg;

    // Width of the saturating message byte counter.
    localparam int unsigned LENGTH_BITS = 16;
    // Width of the length limit register.
    localparam int unsigned MAXLEN_BITS = 16;
    // Common width used when comparing the count against the length limit.
    localparam int unsigned CMP_BITS =
        (LENGTH_BITS > MAXLEN_BITS) ? LENGTH_BITS : MAXLEN_BITS;

    localparam logic [MAXLEN_BITS-1:0] MAXLEN_RESET = MAXLEN_BITS'(255);
    localparam logic [LENGTH_BITS-1:0] COUNT_CEIL  = {LENGTH_BITS{1'b1}};

    // APB register map: word index taken from paddr[2].
    localparam int unsigned APB_ADDR_BITS = 3;
    localparam logic        REG_LENGTH_LIMIT = 1'b0;

    // Byte codes.
    localparam logic [7:0] B_SPACE    = 8'h20;
    localparam logic [7:0] B_DEL      = 8'h7f;
    localparam logic [7:0] B_CONT_LO  = 8'h80;
    localparam logic [7:0] B_CONT_MSK = 8'hc0;
    localparam logic [7:0] B_LEAD2_LO = 8'hc2;
    localparam logic [7:0] B_LEAD2_HI = 8'hdf;
    localparam logic [7:0] B_E0       = 8'he0;
    localparam logic [7:0] B_ED       = 8'hed;
    localparam logic [7:0] B_EF       = 8'hef;
    localparam logic [7:0] B_F0       = 8'hf0;
    localparam logic [7:0] B_F4       = 8'hf4;

    // Allowed range of the second byte of a multi-byte sequence.
    typedef enum logic [2:0] {
        RULE_ANY   = 3'd0,   // 80..BF
        RULE_A0_BF = 3'd1,   // after E0
        RULE_80_9F = 3'd2,   // after ED
        RULE_90_BF = 3'd3,   // after F0
        RULE_80_8F = 3'd4    // after F4
    } t_rule;

    typedef struct packed {
        logic [1:0]             pending;
        t_rule                  rule;
        logic                   expect_second;
        logic                   fault;
        logic [LENGTH_BITS-1:0] count;
    } t_msg_state;

    localparam t_msg_state MSG_CLEAR = '{
        pending:       2'd0,
        rule:          RULE_ANY,
        expect_second: 1'b0,
        fault:         1'b0,
        count:         '0
    };

endpackage

[src/utv_apb_regs.sv]
// APB configuration register holding the message length limit.
module utv_apb_regs (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [utv_pkg::APB_ADDR_BITS-1:0]    paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready,
    output logic [utv_pkg::MAXLEN_BITS-1:0]      o_length_limit
);
    import utv_pkg::*;

    logic [MAXLEN_BITS-1:0] r_length_limit;
    logic                   w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_length_limit <= MAXLEN_RESET;
        end else if (w_wr && (paddr[2] == REG_LENGTH_LIMIT)) begin
            r_length_limit <= pwdata[MAXLEN_BITS-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_LENGTH_LIMIT) begin
            prdata[MAXLEN_BITS-1:0] = r_length_limit;
        end
    end

    assign o_length_limit = r_length_limit;

endmodule

[src/utv_byte_check.sv]
// Per-item next-state logic: sequence tracking, byte rules, length check, verdict.
module utv_byte_check (
    input  utv_pkg::t_msg_state              i_state,
    input  logic [7:0]                       i_byte,
    input  logic                             i_last,
    input  logic                             i_none,
    input  logic [utv_pkg::MAXLEN_BITS-1:0]  i_length_limit,
    output utv_pkg::t_msg_state              o_next,
    output logic                             o_text_ok
);
    import utv_pkg::*;

    t_msg_state w_upd;
    logic       w_cont_ok;
    logic       w_too_long;

    // Continuation byte check, narrowed for the second byte of a sequence.
    always_comb begin
        w_cont_ok = ((i_byte & B_CONT_MSK) == B_CONT_LO);
        if (i_state.expect_second) begin
            case (i_state.rule)
                RULE_A0_BF: w_cont_ok = i_byte inside {[8'ha0:8'hbf]};
                RULE_80_9F: w_cont_ok = i_byte inside {[8'h80:8'h9f]};
                RULE_90_BF: w_cont_ok = i_byte inside {[8'h90:8'hbf]};
                RULE_80_8F: w_cont_ok = i_byte inside {[8'h80:8'h8f]};
                default:    ;
            endcase
        end
    end

    assign w_too_long =
        (CMP_BITS'(i_state.count) >= CMP_BITS'(i_length_limit)) ||
        (i_state.count == COUNT_CEIL);

    always_comb begin
        w_upd = i_state;
        if (!i_none) begin
            if (w_too_long) begin
                w_upd.fault = 1'b1;
            end
            if (i_state.count != COUNT_CEIL) begin
                w_upd.count = i_state.count + LENGTH_BITS'(1);
            end
            if (i_state.pending != 2'd0) begin
                if (!w_cont_ok) begin
                    w_upd.fault = 1'b1;
                end
                w_upd.pending       = i_state.pending - 2'd1;
                w_upd.expect_second = 1'b0;
                w_upd.rule          = RULE_ANY;
            end else if (i_byte < B_CONT_LO) begin
                if ((i_byte < B_SPACE) || (i_byte == B_DEL)) begin
                    w_upd.fault = 1'b1;
                end
            end else if ((i_byte >= B_LEAD2_LO) && (i_byte <= B_LEAD2_HI)) begin
                w_upd.pending       = 2'd1;
                w_upd.rule          = RULE_ANY;
                w_upd.expect_second = 1'b1;
            end else if ((i_byte >= B_E0) && (i_byte <= B_EF)) begin
                w_upd.pending       = 2'd2;
                w_upd.rule          = (i_byte == B_E0) ? RULE_A0_BF :
                                      (i_byte == B_ED) ? RULE_80_9F : RULE_ANY;
                w_upd.expect_second = 1'b1;
            end else if ((i_byte >= B_F0) && (i_byte <= B_F4)) begin
                w_upd.pending       = 2'd3;
                w_upd.rule          = (i_byte == B_F0) ? RULE_90_BF :
                                      (i_byte == B_F4) ? RULE_80_8F : RULE_ANY;
                w_upd.expect_second = 1'b1;
            end else begin
                // stray continuation, C0/C1, or F5..FF as a lead byte
                w_upd.fault = 1'b1;
            end
        end
    end

    assign o_text_ok = !w_upd.fault && (w_upd.pending == 2'd0) &&
                       (w_upd.count != '0);
    assign o_next    = i_last ? MSG_CLEAR : w_upd;

endmodule

[src/utf8_text_validator_unit.sv]
// Top level of the streaming UTF-8 text validator.
//
//  channel   | dir | fields (low bit first)                    | notes
//  ----------+-----+-------------------------------------------+---------------------------
//  s_axis    | in  | tdata[7:0]=data_byte, tlast=is_last,      | one item per byte
//            |     | tuser[0]=no_data                          |
//  m_axis    | out | tdata[0]=text_ok, tdata[7:1]=0            | one item per message
//  apb       | cfg | 0x0: length limit[15:0]                   | pready tied high
//
// One item per cycle sustained while the input stage does not stall. An accepted
// item sits in the input register, where it runs through the byte checker; when
// it advances, the message state updates and, for a message-ending item, the
// verdict register loads, so the verdict passes through the input register and
// the verdict register before it is offered.
// Reset clears the message state and sets the length limit to 255.
// The input stage stalls only when it holds a message-ending item and the
// verdict register is still full with m_axis_tready low.
module utf8_text_validator_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // byte stream in
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [7:0]                           s_axis_tdata,   // [7:0] data_byte
    input  logic                                 s_axis_tlast,
    input  logic [0:0]                           s_axis_tuser,   // [0] no_data
    // verdict out
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [7:0]                           m_axis_tdata,   // [0] text_ok, [7:1] zero
    // configuration
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [utv_pkg::APB_ADDR_BITS-1:0]    paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);
    import utv_pkg::*;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       r_in_none;

    // message state and verdict register
    t_msg_state r_state;
    t_msg_state n_state;
    logic       r_out_valid;
    logic       r_out_ok;
    logic       n_ok;

    logic                   w_advance;
    logic                   w_in_take;
    logic [MAXLEN_BITS-1:0] w_length_limit;

    utv_apb_regs u_regs (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_length_limit (w_length_limit)
    );

    utv_byte_check u_check (
        .i_state        (r_state),
        .i_byte         (r_in_byte),
        .i_last         (r_in_last),
        .i_none         (r_in_none),
        .i_length_limit (w_length_limit),
        .o_next         (n_state),
        .o_text_ok      (n_ok)
    );

    // Only a message-ending item needs room in the verdict register.
    assign w_advance     = r_in_valid && (!r_in_last || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;
    assign w_in_take     = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
            r_in_none <= s_axis_tuser[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MSG_CLEAR;
        end else if (w_advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && r_in_last) begin
            r_out_ok <= n_ok;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'b0, r_out_ok};

endmodule
